// ----- design/thk_pkg.sv -----
// Shared types, constants and hash helper functions for the track key hash block.
package thk_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
  localparam logic [63:0] GOLDEN    = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [2:0]  CNT_MAX   = 3'd7;
  localparam logic [2:0]  CNT_MIN_OK = 3'd2;
  localparam logic [2:0]  CNT_MAX_OK = 3'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       field_end;
    logic       key_end;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic        close;
    logic        key_end;
    logic [63:0] str_hash;
  } close_t;

  // Multiply by the FNV prime 2^40 + 2^8 + 0xb3 as a sum of shifts, modulo 2^64.
  function automatic logic [63:0] fnv_mul(input logic [63:0] x);
    fnv_mul = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  function automatic logic [63:0] fold_in(input logic [63:0] h, input logic [63:0] k);
    fold_in = h ^ (k + GOLDEN + (h << 12) + (h >> 4));
  endfunction

endpackage

// ----- design/track_key_hash.sv -----
// Top level of the track key hash block: input register, FNV stage and combining stage.
//
//   Channel  Direction  tdata                tuser                      tlast
//   in_      slave      data_byte [7:0]      has_byte, field_end        key_end
//   out_     master     key_hash [31:0]      malformed                  -
//
// One word is taken per cycle unless stalled; a key end word passes the input, FNV and result registers.
// The string accumulator loop through the shift-add FNV multiply sets the cycle time.
// Reset is synchronous and returns all key state to its initial values.
// The pipeline stalls only when a key end word must write a result still not taken.
module track_key_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [0] has_byte, [1] field_end
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] key_hash
  output logic        out_tuser   // [0] malformed
);
  import thk_pkg::*;

  logic   en;
  logic   i_valid_r;
  logic   i_valid_nxt;
  item_t  i_item_r;
  item_t  i_item_nxt;
  close_t close_w;

  assign en = !(out_tvalid && !out_tready && close_w.valid && close_w.key_end);
  assign in_tready = en;

  always_comb begin
    i_valid_nxt = en ? in_tvalid : i_valid_r;
    i_item_nxt = i_item_r;
    if (en && in_tvalid) begin
      i_item_nxt.data_byte = in_tdata;
      i_item_nxt.has_byte = in_tuser[0];
      i_item_nxt.field_end = in_tuser[1];
      i_item_nxt.key_end = in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_valid_r <= 1'b0;
    end else begin
      i_valid_r <= i_valid_nxt;
    end
    i_item_r <= i_item_nxt;
  end

  thk_fnv u_fnv (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .item_valid (i_valid_r),
    .item       (i_item_r),
    .close_o    (close_w)
  );

  thk_comb u_comb (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .close_i    (close_w),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .key_hash   (out_tdata),
    .malformed  (out_tuser)
  );

  a_malformed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 32'd0))
    else $error("malformed key carries a non-zero hash");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while the result register was free");

endmodule

// ----- design/thk_fnv.sv -----
// FNV-1a string accumulator stage that hands each closed string hash onwards.
module thk_fnv (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           item_valid,
  input  thk_pkg::item_t item,
  output thk_pkg::close_t close_o
);
  import thk_pkg::*;

  logic [63:0] acc_r;
  logic [63:0] acc_nxt;
  logic [63:0] acc_upd;
  logic        closing;
  close_t      close_r;
  close_t      close_nxt;

  always_comb begin
    acc_upd = item.has_byte ? fnv_mul(acc_r ^ {56'd0, item.data_byte}) : acc_r;
    closing = item.field_end | item.key_end;
    acc_nxt = acc_r;
    close_nxt = close_r;
    if (en) begin
      close_nxt.valid = item_valid;
      close_nxt.close = item_valid & closing;
      close_nxt.key_end = item_valid & item.key_end;
      close_nxt.str_hash = acc_upd;
      if (item_valid) begin
        acc_nxt = closing ? FNV_BASIS : acc_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= FNV_BASIS;
      close_r.valid <= 1'b0;
      close_r.close <= 1'b0;
      close_r.key_end <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      close_r.valid <= close_nxt.valid;
      close_r.close <= close_nxt.close;
      close_r.key_end <= close_nxt.key_end;
    end
    close_r.str_hash <= close_nxt.str_hash;
  end

  assign close_o = close_r;

  a_basis_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    (en && item_valid && closing) |=> (acc_r == FNV_BASIS))
    else $error("string accumulator not restored after a string closed");

  a_key_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    close_r.key_end |-> (close_r.close && close_r.valid))
    else $error("key end word did not close its string");

endmodule

// ----- design/thk_comb.sv -----
// Combining stage that folds string hashes together and holds the result register.
module thk_comb (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  thk_pkg::close_t close_i,
  input  logic            out_tready,
  output logic            out_valid,
  output logic [31:0]     key_hash,
  output logic            malformed
);
  import thk_pkg::*;

  logic [63:0] comb_r;
  logic [63:0] comb_nxt;
  logic [63:0] comb_upd;
  logic [2:0]  cnt_r;
  logic [2:0]  cnt_nxt;
  logic [2:0]  cnt_upd;
  logic        bad;
  logic        emit;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] key_hash_r;
  logic [31:0] key_hash_nxt;
  logic        malformed_r;
  logic        malformed_nxt;

  always_comb begin
    comb_upd = (cnt_r == 3'd0) ? close_i.str_hash : fold_in(comb_r, close_i.str_hash);
    cnt_upd = (cnt_r < CNT_MAX) ? cnt_r + 3'd1 : cnt_r;
    bad = (cnt_upd < CNT_MIN_OK) || (cnt_upd > CNT_MAX_OK);
    emit = en && close_i.valid && close_i.key_end;
    comb_nxt = comb_r;
    cnt_nxt = cnt_r;
    if (en && close_i.valid && close_i.close) begin
      comb_nxt = comb_upd;
      cnt_nxt = cnt_upd;
    end
    if (emit) begin
      comb_nxt = 64'd0;
      cnt_nxt = 3'd0;
    end
    out_valid_nxt = out_valid_r & ~out_tready;
    key_hash_nxt = key_hash_r;
    malformed_nxt = malformed_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      key_hash_nxt = bad ? 32'd0 : comb_upd[31:0];
      malformed_nxt = bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comb_r <= 64'd0;
      cnt_r <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      comb_r <= comb_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_hash_r <= key_hash_nxt;
    malformed_r <= malformed_nxt;
  end

  assign out_valid = out_valid_r;
  assign key_hash = key_hash_r;
  assign malformed = malformed_r;

  a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (cnt_r == 3'd0 && comb_r == 64'd0))
    else $error("key state not cleared after a key end");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_tready))
    else $error("result word overwritten before it was taken");

endmodule
